// ===== rtl/bafb_pkg.sv =====
// Shared types, field widths and operation codes for the bit-addressable field buffer.
// No dependencies; every other file in rtl imports this package.
package bafb_pkg;

	localparam int DEF_CAPACITY_BITS  = 4096;
	localparam int DEF_MAX_FIELD_BITS = 64;

	localparam int OP_W    = 3;
	localparam int FB_W    = 7;
	localparam int POS_W   = 13;
	localparam int DATA_W  = 64;
	localparam int LENB_W  = 13;
	localparam int BYTES_W = 10;

	localparam logic [OP_W-1:0] OP_WRITE       = 3'd0;
	localparam logic [OP_W-1:0] OP_READ        = 3'd1;
	localparam logic [OP_W-1:0] OP_APPEND      = 3'd2;
	localparam logic [OP_W-1:0] OP_CURSOR_READ = 3'd3;
	localparam logic [OP_W-1:0] OP_PAD         = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;

	typedef struct packed {
		logic load;     // capture the accepted item
		logic exec;     // merge, write low word, update length and cursor
		logic wr_hi;    // write the upper word of a straddling field
		logic sweep;    // zero one store word, clear length and cursor
		logic publish;  // move the staged result into the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic need_hi;
		logic sweep_last;
	} ctrl_status_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic [LENB_W-1:0]  length_bits;
		logic [BYTES_W-1:0] length_bytes;
		logic [LENB_W-1:0]  cursor_bits;
		logic               overflow;
	} result_t;

endpackage

// ===== rtl/bit_addressable_field_buffer.sv =====
// Top level of the bit-addressable field buffer: stream ports, output register and
// the sequencer/datapath pair. Depends on bafb_pkg, bafb_ctrl and bafb_datapath.
//
// A fixed-capacity bit store (CAPACITY_BITS bits, LSB-first within bytes, held as
// 64-bit words) with a fill length and a read cursor. Each input item carries one
// operation: write a field at a bit position, read a field at a position, append at
// the fill length, read at the cursor and advance it, pad the length to a byte with
// zero bits, or clear. Each item yields exactly one result item with the read data,
// the length in bits and whole bytes, the cursor and an overflow flag. Fields are up
// to MAX_FIELD_BITS wide; a larger count is saturated. An access that ends past the
// capacity sets overflow: a write is then dropped and a read returns zero.
// Timing: one item is worked at a time. A field may straddle two store words, so an
// item takes a read step (both words fetched from the two-read-port store), a merge
// step that writes the lower word, and, for a straddling write only, one more step
// for the upper word. A done step then moves the result into the output register once
// that register is free, and the next item can be accepted after that. A clear item
// zeroes the store one word per cycle, and its result is registered after the sweep.
// After reset the same sweep runs before the first item is taken. The output register
// lets the next item be accepted while a result waits on the master side.
module bit_addressable_field_buffer #(
	parameter int CAPACITY_BITS  = bafb_pkg::DEF_CAPACITY_BITS,
	parameter int MAX_FIELD_BITS = bafb_pkg::DEF_MAX_FIELD_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// field_bits [6:0], bit_position [19:7], write_data [83:20], zero fill [87:84]
	input  logic [87:0]  s_axis_tdata,
	// op [2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// read_data [63:0], length_bits [76:64], length_bytes [86:77],
	// cursor_bits [99:87], zero fill [103:100]
	output logic [103:0] m_axis_tdata,
	// overflow [0]
	output logic [0:0]   m_axis_tuser
);
	import bafb_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;
	result_t      res;
	logic         in_ready;
	logic         out_free;
	logic         out_valid_q;
	result_t      out_q;

	// the output register is free when empty or being drained this cycle
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = in_ready;

	bafb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	bafb_datapath #(
		.CAPACITY_BITS  (CAPACITY_BITS),
		.MAX_FIELD_BITS (MAX_FIELD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (s_axis_tuser),
		.field_bits   (s_axis_tdata[6:0]),
		.bit_position (s_axis_tdata[19:7]),
		.write_data   (s_axis_tdata[83:20]),
		.status       (status),
		.result       (res)
	);

	// hold the result until the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_q.cursor_bits, out_q.length_bytes,
		out_q.length_bits, out_q.read_data};
	assign m_axis_tuser  = out_q.overflow;

endmodule

// ===== rtl/bafb_ctrl.sv =====
// Sequencer for the field buffer: drives the datapath through read, merge and write
// steps and the clearing sweep. Depends on bafb_pkg.
module bafb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  out_free,
	input  bafb_pkg::ctrl_status_t status,
	output bafb_pkg::ctrl_cmd_t    cmd,
	output logic                  in_ready
);
	import bafb_pkg::*;

	localparam logic [2:0] S_SWEEP_RST = 3'd0;
	localparam logic [2:0] S_IDLE      = 3'd1;
	localparam logic [2:0] S_READ      = 3'd2;
	localparam logic [2:0] S_EXEC      = 3'd3;
	localparam logic [2:0] S_WR_HI     = 3'd4;
	localparam logic [2:0] S_SWEEP_OP  = 3'd5;
	localparam logic [2:0] S_DONE      = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			S_SWEEP_RST: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				state_d = status.is_clear ? S_SWEEP_OP : S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.need_hi ? S_WR_HI : S_DONE;
			end
			S_WR_HI: begin
				cmd.wr_hi = 1'b1;
				state_d   = S_DONE;
			end
			S_SWEEP_OP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP_RST;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/bafb_datapath.sv =====
// Datapath of the field buffer: word store, two-word merge and extract, length and
// cursor registers, clearing counter and result staging. Depends on bafb_pkg.
module bafb_datapath #(
	parameter int CAPACITY_BITS  = bafb_pkg::DEF_CAPACITY_BITS,
	parameter int MAX_FIELD_BITS = bafb_pkg::DEF_MAX_FIELD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bafb_pkg::ctrl_cmd_t            cmd,
	input  logic [bafb_pkg::OP_W-1:0]     op,
	input  logic [bafb_pkg::FB_W-1:0]     field_bits,
	input  logic [bafb_pkg::POS_W-1:0]    bit_position,
	input  logic [bafb_pkg::DATA_W-1:0]   write_data,
	output bafb_pkg::ctrl_status_t         status,
	output bafb_pkg::result_t              result
);
	import bafb_pkg::*;

	localparam int LEN_W       = $clog2(CAPACITY_BITS + 1);
	localparam int END_W       = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
	localparam int STORE_WORDS = (CAPACITY_BITS + 63) / 64;
	localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

	logic [DATA_W-1:0] mem [STORE_WORDS];

	logic [OP_W-1:0]   op_q;
	logic [FB_W-1:0]   n_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] data_q;
	logic [LEN_W-1:0]  fill_q;
	logic [LEN_W-1:0]  cursor_q;
	logic [AW-1:0]     clr_cnt_q;
	logic [DATA_W-1:0] rd_lo_q;
	logic [DATA_W-1:0] rd_hi_q;
	logic [AW-1:0]     hi_addr_q;
	logic [DATA_W-1:0] hi_data_q;
	logic [DATA_W-1:0] rd_res_q;
	logic              ovf_res_q;

	logic [FB_W-1:0]   n_sat;
	logic [END_W-1:0]  fill_ext;
	logic [END_W-1:0]  pos_ext;
	logic [END_W-1:0]  cur_ext;
	logic [2:0]        pad_n;
	logic [END_W-1:0]  p_eff;
	logic [FB_W-1:0]   n_eff;
	logic [DATA_W-1:0] d_eff;
	logic              is_wr;
	logic              is_rd;
	logic [END_W-1:0]  n_ext;
	logic [END_W-1:0]  end_eff;
	logic              ovf_hit;
	logic [END_W-1:0]  w_full;
	logic [END_W-1:0]  w_next;
	logic [5:0]        ofs;
	logic              lo_ok;
	logic              hi_ok;
	logic [AW-1:0]     raddr_lo;
	logic [AW-1:0]     raddr_hi;
	logic [DATA_W-1:0] mask64;
	logic [2*DATA_W-1:0] win;
	logic [2*DATA_W-1:0] mask_w;
	logic [2*DATA_W-1:0] data_w;
	logic [2*DATA_W-1:0] merged;
	logic [2*DATA_W-1:0] rd_win;
	logic              wr_ok;
	logic              we_lo;
	logic [7:0]        span;
	logic [END_W-1:0]  nc;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [LEN_W:0]    fill_p7;
	logic [LEN_W+BYTES_W:0] bytes_ext;
	logic [LEN_W+LENB_W:0]  fill_out;
	logic [LEN_W+LENB_W:0]  cur_out;

	assign n_sat = (field_bits > FB_W'(MAX_FIELD_BITS)) ? FB_W'(MAX_FIELD_BITS) : field_bits;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			n_q    <= n_sat;
			pos_q  <= bit_position;
			data_q <= write_data;
		end
	end

	assign fill_ext = {{(END_W-LEN_W){1'b0}}, fill_q};
	assign cur_ext  = {{(END_W-LEN_W){1'b0}}, cursor_q};
	assign pos_ext  = {{(END_W-POS_W){1'b0}}, pos_q};
	// zero bits needed to reach the next byte boundary
	assign pad_n    = 3'd0 - fill_q[2:0];

	always_comb begin
		p_eff = pos_ext;
		n_eff = n_q;
		d_eff = data_q;
		is_wr = 1'b0;
		is_rd = 1'b0;
		unique case (op_q)
			OP_WRITE: begin
				is_wr = 1'b1;
			end
			OP_READ: begin
				is_rd = 1'b1;
			end
			OP_APPEND: begin
				p_eff = fill_ext;
				is_wr = 1'b1;
			end
			OP_CURSOR_READ: begin
				p_eff = cur_ext;
				is_rd = 1'b1;
			end
			OP_PAD: begin
				p_eff = fill_ext;
				n_eff = {4'b0, pad_n};
				d_eff = '0;
				is_wr = 1'b1;
			end
			default: begin
				n_eff = '0;
			end
		endcase
	end

	assign n_ext    = {{(END_W-FB_W){1'b0}}, n_eff};
	assign end_eff  = p_eff + n_ext;
	assign ovf_hit  = end_eff > END_W'(CAPACITY_BITS);
	assign w_full   = p_eff >> 6;
	assign w_next   = w_full + END_W'(1);
	assign ofs      = p_eff[5:0];
	assign lo_ok    = w_full < END_W'(STORE_WORDS);
	assign hi_ok    = w_next < END_W'(STORE_WORDS);
	assign raddr_lo = lo_ok ? w_full[AW-1:0] : '0;
	assign raddr_hi = hi_ok ? w_next[AW-1:0] : '0;

	// both words are read every cycle; the addresses hold from the read step to the merge
	always_ff @(posedge clk) begin
		rd_lo_q <= mem[raddr_lo];
		rd_hi_q <= mem[raddr_hi];
	end

	assign mask64 = ~({DATA_W{1'b1}} << n_eff);
	assign win    = {(hi_ok ? rd_hi_q : {DATA_W{1'b0}}), rd_lo_q};
	assign mask_w = {{DATA_W{1'b0}}, mask64} << ofs;
	assign data_w = {{DATA_W{1'b0}}, d_eff & mask64} << ofs;
	assign merged = (win & ~mask_w) | data_w;
	assign rd_win = win >> ofs;

	assign wr_ok   = is_wr && !ovf_hit;
	assign we_lo   = wr_ok && (n_eff != '0);
	assign span    = {2'b0, ofs} + {1'b0, n_eff};
	assign nc      = cur_ext + n_ext;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = raddr_lo;
		mem_wdata = merged[DATA_W-1:0];
		if (cmd.sweep) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (cmd.wr_hi) begin
			mem_we    = 1'b1;
			mem_waddr = hi_addr_q;
			mem_wdata = hi_data_q;
		end else if (cmd.exec) begin
			mem_we    = we_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			hi_addr_q <= raddr_hi;
			hi_data_q <= merged[2*DATA_W-1:DATA_W];
			rd_res_q  <= (is_rd && !ovf_hit) ? (rd_win[DATA_W-1:0] & mask64) : '0;
			ovf_res_q <= (is_wr || is_rd) && ovf_hit;
		end else if (cmd.sweep) begin
			rd_res_q  <= '0;
			ovf_res_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			cursor_q  <= '0;
			clr_cnt_q <= '0;
		end else if (cmd.sweep) begin
			fill_q    <= '0;
			cursor_q  <= '0;
			clr_cnt_q <= status.sweep_last ? '0 : clr_cnt_q + AW'(1);
		end else if (cmd.exec) begin
			if (wr_ok && (end_eff > fill_ext)) begin
				fill_q <= end_eff[LEN_W-1:0];
			end
			if (op_q == OP_CURSOR_READ) begin
				cursor_q <= (nc > END_W'(CAPACITY_BITS)) ? LEN_W'(CAPACITY_BITS) : nc[LEN_W-1:0];
			end
		end
	end

	assign status.is_clear   = (op_q == OP_CLEAR);
	assign status.need_hi    = we_lo && (span > 8'd64);
	assign status.sweep_last = (clr_cnt_q == AW'(STORE_WORDS - 1));

	assign fill_p7   = {1'b0, fill_q} + (LEN_W+1)'(7);
	assign bytes_ext = {{BYTES_W{1'b0}}, fill_p7} >> 3;
	assign fill_out  = {{(LENB_W+1){1'b0}}, fill_q};
	assign cur_out   = {{(LENB_W+1){1'b0}}, cursor_q};

	assign result.read_data    = rd_res_q;
	assign result.length_bits  = fill_out[LENB_W-1:0];
	assign result.length_bytes = bytes_ext[BYTES_W-1:0];
	assign result.cursor_bits  = cur_out[LENB_W-1:0];
	assign result.overflow     = ovf_res_q;

endmodule

// ===== dv/tb.sv =====
// Testbench for the bit-addressable field buffer: drives operation items on the slave
// stream, predicts every result from a bit-level copy of the store, checks the master stream.
// Depends on bafb_pkg and bit_addressable_field_buffer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bafb_pkg::*;

	localparam int CAP_BITS     = DEF_CAPACITY_BITS;
	localparam int MAX_FIELD    = DEF_MAX_FIELD_BITS;
	localparam int RANDOM_ITEMS = 1740;
	localparam int CYCLE_LIMIT  = 1000000;
	// a clear sweeps one word per cycle; allow that plus the pipeline
	localparam int TAIL_CYCLES  = CAP_BITS / 64 + 16;

	// op codes the block leaves unused
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [87:0]  s_axis_tdata  = '0;
	logic [2:0]   s_axis_tuser  = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	// predicted contents of the block
	bit [CAP_BITS-1:0] model_store;
	int unsigned       model_fill;
	int unsigned       model_cursor;

	result_t     pending_results[$];
	int unsigned failures    = 0;
	int unsigned cycle_count = 0;
	bit          quiet       = 1'b0;   // when set, neither side idles

	bit_addressable_field_buffer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Store a field; drop it whole and flag overflow if it ends past capacity.
	function automatic bit store_field(int unsigned pos, int unsigned n, logic [63:0] data);
		int unsigned stop;
		stop = pos + n;
		if (stop > CAP_BITS)
			return 1'b1;
		for (int unsigned i = 0; i < n; i++)
			model_store[pos + i] = data[i];
		if (stop > model_fill)
			model_fill = stop;
		return 1'b0;
	endfunction

	// Fetch a field; zero and overflow if it ends past capacity.
	function automatic bit fetch_field(int unsigned pos, int unsigned n,
			output logic [63:0] data);
		data = '0;
		if (pos + n > CAP_BITS)
			return 1'b1;
		for (int unsigned i = 0; i < n; i++)
			data[i] = model_store[pos + i];
		return 1'b0;
	endfunction

	// Apply one operation to the predicted state and return the result it yields.
	function automatic result_t field_buffer_step(logic [OP_W-1:0] op, logic [FB_W-1:0] n_raw,
			logic [POS_W-1:0] pos, logic [63:0] data);
		int unsigned n;
		logic [63:0] rd;
		result_t     r;
		n  = (n_raw > MAX_FIELD) ? MAX_FIELD : n_raw;
		rd = '0;
		r  = '0;
		case (op)
			OP_WRITE:       r.overflow = store_field(pos, n, data);
			OP_READ:        r.overflow = fetch_field(pos, n, rd);
			OP_APPEND:      r.overflow = store_field(model_fill, n, data);
			OP_CURSOR_READ: begin
				r.overflow   = fetch_field(model_cursor, n, rd);
				model_cursor = (model_cursor + n > CAP_BITS) ? CAP_BITS : model_cursor + n;
			end
			OP_PAD:         r.overflow = store_field(model_fill, (8 - model_fill % 8) % 8, '0);
			OP_CLEAR: begin
				model_store  = '0;
				model_fill   = 0;
				model_cursor = 0;
			end
			default: ;
		endcase
		r.read_data    = rd;
		r.length_bits  = LENB_W'(model_fill);
		r.length_bytes = BYTES_W'((model_fill + 7) / 8);
		r.cursor_bits  = LENB_W'(model_cursor);
		return r;
	endfunction

	// Present one item after a random gap, hold it until taken, then record the prediction.
	task automatic send_item(logic [OP_W-1:0] op, logic [FB_W-1:0] n, logic [POS_W-1:0] pos,
			logic [63:0] data);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, data, pos, n};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		pending_results.push_back(field_buffer_step(op, n, pos, data));
	endtask

	// Hold the sender off until every predicted result has come back.
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			failures++;
		end
	endtask

	// Take results after a random stall and compare them with the oldest prediction.
	initial begin : result_checker
		result_t     want;
		int unsigned stall;
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			if (pending_results.size() == 0) begin
				$display("%0t: result expected none actual %h/%b", $time, m_axis_tdata,
					m_axis_tuser);
				failures++;
			end else begin
				want = pending_results.pop_front();
				check_field("read_data", want.read_data, m_axis_tdata[63:0]);
				check_field("length_bits", want.length_bits, m_axis_tdata[76:64]);
				check_field("length_bytes", want.length_bytes, m_axis_tdata[86:77]);
				check_field("cursor_bits", want.cursor_bits, m_axis_tdata[99:87]);
				check_field("overflow", want.overflow, m_axis_tuser);
			end
		end
	end

	// Field extremes, every op and the edge cases at and past capacity.
	task automatic test_directed_cases();
		send_item(OP_WRITE, 7'd64, 13'd0, '1);
		send_item(OP_READ, 7'd64, 13'd0, '0);
		// straddle two store words
		send_item(OP_WRITE, 7'd64, 13'd100, 64'ha5a5_5a5a_f00f_0ff0);
		send_item(OP_READ, 7'd70, 13'd98, '0);          // count saturates
		send_item(OP_WRITE, 7'd0, 13'd200, '1);         // empty write still moves length
		send_item(OP_READ, 7'd0, 13'd0, '0);
		send_item(OP_APPEND, 7'd127, 13'd0, {$urandom, $urandom});
		send_item(OP_APPEND, 7'd3, 13'd0, '1);
		send_item(OP_PAD, 7'd0, 13'd0, '0);
		send_item(OP_PAD, 7'd0, 13'd0, '0);             // already aligned
		send_item(OP_CURSOR_READ, 7'd13, 13'd0, '0);
		send_item(OP_CURSOR_READ, 7'd64, 13'd0, '0);
		send_item(OP_WRITE, 7'd64, 13'd4032, {$urandom, $urandom});  // ends exactly at capacity
		send_item(OP_READ, 7'd64, 13'd4032, '0);
		send_item(OP_WRITE, 7'd10, 13'd4090, '1);       // past capacity: dropped
		send_item(OP_WRITE, 7'd127, 13'd8191, '1);
		send_item(OP_READ, 7'd64, 13'd4033, '0);
		send_item(OP_READ, 7'd0, 13'd8191, '0);
		send_item(OP_APPEND, 7'd1, 13'd0, '1);          // store full
		send_item(OP_PAD, 7'd0, 13'd0, '0);
		send_item(OP_SPARE_6, 7'd127, 13'd8191, '1);
		send_item(OP_SPARE_7, 7'd64, 13'd0, '1);
		send_item(OP_CLEAR, 7'd0, 13'd0, '0);
		send_item(OP_READ, 7'd64, 13'd0, '0);
		send_item(OP_CURSOR_READ, 7'd0, 13'd0, '0);
	endtask

	// Fill the whole store by appends, then drain it with cursor reads past its end.
	task automatic test_fill_and_drain();
		quiet = 1'b1;
		send_item(OP_CLEAR, 7'd0, 13'd0, '0);
		for (int i = 0; i < CAP_BITS / 64; i++)
			send_item(OP_APPEND, 7'd64, 13'd0, {$urandom, $urandom});
		send_item(OP_APPEND, 7'd1, 13'd0, '1);
		quiet = 1'b0;
		// misalign the cursor so every 64-bit read in the loop below straddles
		send_item(OP_CURSOR_READ, 7'd5, 13'd0, '0);
		for (int i = 0; i < CAP_BITS / 64; i++)
			send_item(OP_CURSOR_READ, 7'd64, 13'd0, '0);
		send_item(OP_CURSOR_READ, 7'd10, 13'd0, '0);    // cursor pinned at capacity
		wait_for_drain();
		send_item(OP_CLEAR, 7'd0, 13'd0, '0);
	endtask

	// Random well-formed traffic, about half of it inside the filled region, with noise items mixed in.
	task automatic test_random_mix();
		int unsigned      roll;
		logic [FB_W-1:0]  n;
		logic [POS_W-1:0] pos;
		logic [63:0]      data;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (i % 400 == 399)
				wait_for_drain();
			roll = $urandom_range(0, 19);
			if (roll == 0)
				n = FB_W'($urandom_range(MAX_FIELD + 1, 127));
			else if (roll == 1)
				n = FB_W'(MAX_FIELD);
			else
				n = FB_W'($urandom_range(0, MAX_FIELD));
			data = {$urandom, $urandom};
			roll = $urandom_range(0, 7);
			if (roll < 4)
				pos = POS_W'($urandom_range(0, model_fill));
			else if (roll < 6)
				pos = POS_W'($urandom_range(0, CAP_BITS - 1));
			else if (roll == 6)
				pos = POS_W'($urandom_range(CAP_BITS - 80, CAP_BITS));
			else
				pos = POS_W'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 22)
				send_item(OP_WRITE, n, pos, data);
			else if (roll < 44)
				send_item(OP_READ, n, pos, data);
			else if (roll < 60)
				send_item(OP_APPEND, n, pos, data);
			else if (roll < 76)
				send_item(OP_CURSOR_READ, n, pos, data);
			else if (roll < 85)
				send_item(OP_PAD, n, pos, data);
			else if (roll < 87)
				send_item(OP_CLEAR, n, pos, data);
			else if (roll < 90)
				send_item(roll[0] ? OP_SPARE_6 : OP_SPARE_7, n, pos, data);
			else
				send_item(OP_W'($urandom_range(0, 7)), FB_W'($urandom), POS_W'($urandom), data);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_fill_and_drain();
		test_random_mix();
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
